[hdl/rsts_pkg.sv]
// ----------------------------------------------------------------------------
// rsts_pkg
// Shared types, constants and helpers for the rotated sorted table search.
// ----------------------------------------------------------------------------
package rsts_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int DATA_W      = 32;
   localparam int SIZE_W      = 11;
   localparam int IDX_W       = 10;
   localparam int POS_W       = ADDR_W + 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // Command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Register indexes
   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   // Signed search bound, wide enough to hold -1 and TABLE_DEPTH
   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      logic                     cmd;
      logic [IDX_W-1:0]         entry_index;
      logic signed [DATA_W-1:0] entry_value;
      logic signed [DATA_W-1:0] search_key;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_index;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // Midpoint of two non-negative bounds
   function automatic logic [ADDR_W-1:0] mid_of(input pos_type lo, input pos_type hi);
      logic [POS_W:0] sum;
      sum = {lo[POS_W-1], lo} + {hi[POS_W-1], hi};
      return sum[ADDR_W:1];
   endfunction

endpackage

[hdl/rsts_ram.sv]
// ----------------------------------------------------------------------------
// rsts_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsts_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Store one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rsts_ctrl.sv]
// ----------------------------------------------------------------------------
// rsts_ctrl
// Search sequencer: pivot bisection then binary search, one table read per
// cycle through the RAM read port; table writes go straight to the RAM.
// ----------------------------------------------------------------------------
module rsts_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  rsts_pkg::req_type             req_payload,
   input  logic [rsts_pkg::SIZE_W-1:0]   entries_in_use,
   input  logic [rsts_pkg::DATA_W-1:0]   rd_data,
   output rsts_pkg::mem_req_type         mem_req,
   output logic                          busy,
   output logic                          rsp_valid,
   output rsts_pkg::rsp_type             rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_PIVOT,
      ST_CHECK,
      ST_BSEARCH
   } state_type;

   state_type                         state_ff, state_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   rsts_pkg::rsp_type                 rsp_ff, rsp_in;
   logic signed [rsts_pkg::DATA_W-1:0] key_ff, key_in;
   logic signed [rsts_pkg::DATA_W-1:0] first_val_ff, first_val_in;
   logic signed [rsts_pkg::DATA_W-1:0] last_val_ff, last_val_in;
   logic [rsts_pkg::ADDR_W-1:0]       last_ff, last_in;
   logic [rsts_pkg::ADDR_W-1:0]       mid_ff, mid_in;
   rsts_pkg::pos_type                 lo_ff, lo_in;
   rsts_pkg::pos_type                 hi_ff, hi_in;

   rsts_pkg::pos_type                 lo_nx, hi_nx, mid_pos, last_pos;
   logic [rsts_pkg::ADDR_W-1:0]       mid_nx;
   logic [rsts_pkg::SIZE_W-1:0]       size_clamped, size_less_one;
   logic signed [rsts_pkg::DATA_W-1:0] rd_val;

   assign rd_val   = $signed(rd_data);
   assign mid_pos  = rsts_pkg::pos_type'({2'b00, mid_ff});
   assign last_pos = rsts_pkg::pos_type'({2'b00, last_ff});

   // Clamp the array size to the table depth
   always_comb begin
      if (entries_in_use > rsts_pkg::SIZE_W'(rsts_pkg::TABLE_DEPTH)) begin
         size_clamped = rsts_pkg::SIZE_W'(rsts_pkg::TABLE_DEPTH);
      end else begin
         size_clamped = entries_in_use;
      end
      size_less_one = size_clamped - rsts_pkg::SIZE_W'(1);
   end

   // Next state, bounds and table access
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      key_in       = key_ff;
      first_val_in = first_val_ff;
      last_val_in  = last_val_ff;
      last_in      = last_ff;
      mid_in       = mid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo_nx        = lo_ff;
      hi_nx        = hi_ff;
      mid_nx       = '0;
      mem_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_payload.cmd == rsts_pkg::CMD_WRITE) begin
                  mem_req.wr_en   = 32'(req_payload.entry_index) <
                                    32'(rsts_pkg::TABLE_DEPTH);
                  mem_req.wr_addr = req_payload.entry_index[rsts_pkg::ADDR_W-1:0];
                  mem_req.wr_data = req_payload.entry_value;
               end else begin
                  key_in = req_payload.search_key;
                  if (size_clamped == '0) begin
                     // empty array: report a miss at once
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end else begin
                     last_in         = size_less_one[rsts_pkg::ADDR_W-1:0];
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                     state_in        = ST_FIRST;
                  end
               end
            end
         end

         ST_FIRST: begin
            // Hold entry 0, fetch the last entry
            first_val_in    = rd_val;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = last_ff;
            lo_in           = '0;
            hi_in           = last_pos;
            state_in        = ST_LAST;
         end

         ST_LAST: begin
            last_val_in = rd_val;
            mid_nx      = rsts_pkg::mid_of(lo_ff, hi_ff);
            if (lo_ff < hi_ff) begin
               mid_in          = mid_nx;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid_nx;
               state_in        = ST_PIVOT;
            end else begin
               // single entry: pivot is entry 0
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = lo_ff[rsts_pkg::ADDR_W-1:0];
               state_in        = ST_CHECK;
            end
         end

         ST_PIVOT: begin
            // Advance the pivot bisection by one step
            if (rd_val >= first_val_ff) begin
               lo_nx = mid_pos + rsts_pkg::pos_type'(1);
            end else begin
               hi_nx = mid_pos;
            end
            lo_in  = lo_nx;
            hi_in  = hi_nx;
            mid_nx = rsts_pkg::mid_of(lo_nx, hi_nx);
            mem_req.rd_en = 1'b1;
            if (lo_nx < hi_nx) begin
               mid_in          = mid_nx;
               mem_req.rd_addr = mid_nx;
            end else begin
               mem_req.rd_addr = lo_nx[rsts_pkg::ADDR_W-1:0];
               state_in        = ST_CHECK;
            end
         end

         ST_CHECK: begin
            // Pick the sorted half that can hold the key
            if (rd_val <= key_ff && key_ff <= last_val_ff) begin
               lo_nx = lo_ff;
               hi_nx = last_pos;
            end else begin
               lo_nx = '0;
               hi_nx = lo_ff - rsts_pkg::pos_type'(1);
            end
            lo_in  = lo_nx;
            hi_in  = hi_nx;
            mid_nx = rsts_pkg::mid_of(lo_nx, hi_nx);
            if (lo_nx <= hi_nx) begin
               mid_in          = mid_nx;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid_nx;
               state_in        = ST_BSEARCH;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
            end
         end

         ST_BSEARCH: begin
            if (rd_val == key_ff) begin
               rsp_valid_in      = 1'b1;
               rsp_in.found      = 1'b1;
               rsp_in.match_index = rsts_pkg::IDX_W'(mid_ff);
               state_in          = ST_IDLE;
            end else begin
               // Narrow the window
               if (rd_val > key_ff) begin
                  hi_nx = mid_pos - rsts_pkg::pos_type'(1);
               end else begin
                  lo_nx = mid_pos + rsts_pkg::pos_type'(1);
               end
               lo_in  = lo_nx;
               hi_in  = hi_nx;
               mid_nx = rsts_pkg::mid_of(lo_nx, hi_nx);
               if (lo_nx <= hi_nx) begin
                  mid_in          = mid_nx;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = mid_nx;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  state_in     = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff       <= rsp_in;
      key_ff       <= key_in;
      first_val_ff <= first_val_in;
      last_val_ff  <= last_val_in;
      last_ff      <= last_in;
      mid_ff       <= mid_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/rotated_sorted_table_search.sv]
// ----------------------------------------------------------------------------
// rotated_sorted_table_search
// Search for a key in a table that holds a rotated ascending array.
// ----------------------------------------------------------------------------
// A write transaction (cmd 0) stores one entry; busy stays low and no
// result follows. A search transaction (cmd 1) raises busy, reads
// entry 0 and the last entry, bisects for the rotation pivot, then runs a
// binary search over the sorted half that can hold the key. The single
// table read port does one read per cycle. The result shows on rsp_valid
// for one cycle as busy drops, and must be taken then: there is no way to
// stall it. An entries_in_use of zero answers a miss in the cycle after
// the request, and busy stays low. Table entries are undefined until
// written.
// ----------------------------------------------------------------------------
module rotated_sorted_table_search (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rsts_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   output rsts_pkg::rsp_type     rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [rsts_pkg::SIZE_W-1:0] entries_ff;
   logic                        csr_wr;
   rsts_pkg::mem_req_type       mem_req;
   logic [rsts_pkg::DATA_W-1:0] rd_data;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= rsts_pkg::SIZE_RESET;
      end else if (csr_wr && csr_paddr[2] == rsts_pkg::REG_ENTRIES_IN_USE) begin
         entries_ff <= csr_pwdata[rsts_pkg::SIZE_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == rsts_pkg::REG_ENTRIES_IN_USE) begin
         csr_prdata = 32'(entries_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   rsts_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_payload    (req_payload),
      .entries_in_use (entries_ff),
      .rd_data        (rd_data),
      .mem_req        (mem_req),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload)
   );

   rsts_ram #(
      .DEPTH (rsts_pkg::TABLE_DEPTH),
      .WIDTH (rsts_pkg::DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   // A table write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == rsts_pkg::CMD_WRITE) |=> !rsp_valid)
      else $error("result after a write transaction");

   // A search that ends always reports
   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("search ended without a result");

   // A miss reports index zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.found) |-> (rsp_payload.match_index == '0))
      else $error("miss with nonzero index");

   // A result follows a search in progress or a search request
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without a search");
`endif

endmodule

[dv/rotated_sorted_table_search_tb.sv]
// ----------------------------------------------------------------------------
// rotated_sorted_table_search_tb
// Self-checking bench for the rotated sorted table search.
// ----------------------------------------------------------------------------
// The bench loads the table with rotated ascending arrays and sometimes
// breaks their order. Searched entry counts run from zero up to 200;
// counts past the table depth go through the register port and are read
// back. Keys are drawn to hit entries, fall between entries and
// sit at the extremes of the value range. A shadow copy of the table and
// of the size register is updated as each transaction is accepted. Each
// search is predicted then, and every result strobe is checked against the
// oldest prediction. The size register is changed only while the block is
// idle, and each setting is read back over the register port.
// ----------------------------------------------------------------------------
module rotated_sorted_table_search_tb;

   localparam int SETTLE_CYCLES = 30;
   localparam int QUIET_LIMIT   = 3000;
   localparam int RANDOM_ITEMS  = 800;

   localparam logic [2:0] SIZE_ADDR     = {rsts_pkg::REG_ENTRIES_IN_USE, 2'b00};
   localparam logic [2:0] UNMAPPED_ADDR = {~rsts_pkg::REG_ENTRIES_IN_USE, 2'b00};

   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic              busy;
   rsts_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   rsts_pkg::rsp_type rsp_payload;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [2:0]        csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // Transactions waiting to be driven, and search answers still owed
   rsts_pkg::req_type cmd_queue[$];
   rsts_pkg::rsp_type pending_answers[$];

   // Shadow state, updated as transactions and register writes complete
   logic signed [31:0]          shadow_table [rsts_pkg::TABLE_DEPTH];
   logic [rsts_pkg::SIZE_W-1:0] shadow_size = rsts_pkg::SIZE_RESET;

   // Table contents as planned by the stimulus, ahead of acceptance
   logic signed [31:0] plan_table [rsts_pkg::TABLE_DEPTH];

   logic holding     = 1'b0;
   logic steady_feed = 1'b0;
   int   gap_left    = 0;
   int   quiet_cycles = 0;
   int   mismatches  = 0;
   int   search_count = 0;
   int   write_count = 0;
   int   hit_count   = 0;
   int   size_settings = 0;
   int   random_items = 0;

   rotated_sorted_table_search u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Binary search over lo..hi inclusive of the shadow table; -1 on a miss
   function automatic int bisect_shadow(input int lo, input int hi,
                                        input logic signed [31:0] key);
      int a;
      int b;
      int mid;
      a = lo;
      b = hi;
      while (a <= b) begin
         mid = a + (b - a) / 2;
         if (shadow_table[mid] == key) begin
            return mid;
         end
         if (shadow_table[mid] > key) begin
            b = mid - 1;
         end else begin
            a = mid + 1;
         end
      end
      return -1;
   endfunction

   // Locate the rotation pivot, then search the half that can hold the key
   function automatic rsts_pkg::rsp_type locate_key(input logic signed [31:0] key);
      rsts_pkg::rsp_type answer;
      int      n;
      int      lo;
      int      hi;
      int      mid;
      int      last;
      int      hit;
      n   = (shadow_size > rsts_pkg::TABLE_DEPTH) ? rsts_pkg::TABLE_DEPTH
                                                  : int'(shadow_size);
      hit = -1;
      if (n > 0) begin
         last = n - 1;
         lo   = 0;
         hi   = last;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_table[mid] >= shadow_table[0]) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         if (shadow_table[lo] <= key && key <= shadow_table[last]) begin
            hit = bisect_shadow(lo, last, key);
         end else begin
            hit = bisect_shadow(0, lo - 1, key);
         end
      end
      answer.found       = (hit >= 0);
      answer.match_index = (hit >= 0) ? hit[rsts_pkg::IDX_W-1:0] : '0;
      return answer;
   endfunction

   // Mostly back to back, some short pauses, a few long ones
   function automatic int pick_gap();
      int roll;
      if (steady_feed) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Drive queued transactions; predict each one as it is accepted
   always @(posedge clock) begin : feed_requests
      rsts_pkg::rsp_type answer;
      if (reset) begin
         start    <= 1'b0;
         holding  = 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            holding = 1'b0;
            if (req_payload.cmd == rsts_pkg::CMD_WRITE) begin
               shadow_table[req_payload.entry_index] = req_payload.entry_value;
               write_count++;
            end else begin
               answer = locate_key(req_payload.search_key);
               pending_answers.push_back(answer);
               search_count++;
            end
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               req_payload <= cmd_queue.pop_front();
               holding  = 1'b1;
               start    <= 1'b1;
               gap_left = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Check every result strobe against the oldest prediction
   always @(posedge clock) begin : check_answers
      rsts_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("result with no search outstanding: found=%0d match_index=%0d",
                   rsp_payload.found, rsp_payload.match_index);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_payload.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_payload.found);
               mismatches++;
            end
            if (rsp_payload.match_index !== want.match_index) begin
               $error("match_index: expected %0d, got %0d",
                      want.match_index, rsp_payload.match_index);
               mismatches++;
            end
            if (want.found) begin
               hit_count++;
            end
         end
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin : watchdog
      if ((start && !busy) || rsp_valid || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic queue_write(input int idx, input logic signed [31:0] value);
      rsts_pkg::req_type item;
      item.cmd         = rsts_pkg::CMD_WRITE;
      item.entry_index = idx[rsts_pkg::IDX_W-1:0];
      item.entry_value = value;
      item.search_key  = $urandom;
      plan_table[idx]  = value;
      cmd_queue.push_back(item);
   endtask

   task automatic queue_search(input logic signed [31:0] key);
      rsts_pkg::req_type item;
      item.cmd         = rsts_pkg::CMD_SEARCH;
      item.entry_index = $urandom;
      item.entry_value = $urandom;
      item.search_key  = key;
      cmd_queue.push_back(item);
   endtask

   // Hold until every transaction is taken and every answer is in
   task automatic wait_drain();
      while (cmd_queue.size() != 0 || holding || pending_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read the size register back and compare with the shadow copy
   task automatic check_size_readback();
      logic [31:0] data;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SIZE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (data !== 32'(shadow_size)) begin
         $error("entries_in_use: expected %0d, got %0d", shadow_size, data);
         mismatches++;
      end
   endtask

   // Change the entry count while idle; optionally dirty the unused upper bits
   task automatic set_size(input int size, input bit dirty);
      logic [31:0] data;
      wait_drain();
      data = 32'(size);
      if (dirty) begin
         data = ($urandom & ~32'h7FF) | (data & 32'h7FF);
      end
      csr_write(SIZE_ADDR, data);
      shadow_size = data[rsts_pkg::SIZE_W-1:0];
      size_settings++;
      check_size_readback();
   endtask

   // Write entries 0..n-1 as an ascending run rotated by a random amount
   task automatic load_rotated(input int n);
      logic signed [31:0] ordered [rsts_pkg::TABLE_DEPTH];
      longint             cur;
      longint             step_max;
      int                 rot;
      int                 i;
      if ($urandom_range(0, 2) != 0) begin
         step_max = 64'h0000_0000_FFFF_FFFF / n;
         cur      = -64'sd2147483648 + $urandom_range(0, 32'(step_max));
      end else begin
         // Narrow steps give runs of equal entries
         step_max = $urandom_range(0, 3);
         cur      = longint'($signed($urandom));
         if (cur > 64'sd2147483647 - 4096) begin
            cur = cur - 8192;
         end
      end
      for (i = 0; i < n; i++) begin
         ordered[i] = cur[31:0];
         cur = cur + $urandom_range(0, 32'(step_max));
      end
      rot = $urandom_range(0, n - 1);
      for (i = 0; i < n; i++) begin
         queue_write(i, ordered[(i + rot) % n]);
      end
      random_items += n;
   endtask

   // Keys that hit, keys next to entries, random keys and range extremes
   function automatic logic signed [31:0] pick_key(input int n);
      int roll;
      roll = $urandom_range(0, 99);
      if (n == 0 || roll >= 95) begin
         return $urandom;
      end else if (roll < 50) begin
         return plan_table[$urandom_range(0, n - 1)];
      end else if (roll < 70) begin
         return plan_table[$urandom_range(0, n - 1)] + (roll[0] ? 32'sd1 : -32'sd1);
      end else if (roll < 80) begin
         return (roll < 75) ? MOST_NEGATIVE : MOST_POSITIVE;
      end else if (roll < 88) begin
         return plan_table[0] - 32'sd1;
      end
      return plan_table[n - 1] + 32'sd1;
   endfunction

   // One setting of the entry count followed by a burst of searches
   task automatic run_phase(input int size, input bit reload, input int searches);
      int n;
      int k;
      bit scramble;
      n = (size > rsts_pkg::TABLE_DEPTH) ? rsts_pkg::TABLE_DEPTH : size;
      steady_feed = ($urandom_range(0, 3) == 0);
      set_size(size, $urandom_range(0, 1));
      if (reload && n > 0) begin
         load_rotated(n);
      end
      // Break the order in some phases
      scramble = (n > 0) && ($urandom_range(0, 6) == 0);
      if (scramble) begin
         repeat ($urandom_range(1, 3)) begin
            queue_write($urandom_range(0, n - 1), $urandom);
            random_items++;
         end
      end
      for (k = 0; k < searches; k++) begin
         if (scramble && $urandom_range(0, 9) == 0) begin
            queue_write($urandom_range(0, n - 1), $urandom);
            random_items++;
         end
         queue_search(pick_key(n));
         random_items++;
      end
   endtask

   initial begin : stimulus
      int roll;
      int size;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset value, then a write to an unmapped address that must not land
      wait_drain();
      check_size_readback();
      csr_write(UNMAPPED_ADDR, 32'h0000_0005);
      check_size_readback();

      // Single entry at the negative extreme
      set_size(1, 1'b0);
      queue_write(0, MOST_NEGATIVE);
      queue_search(MOST_NEGATIVE);
      queue_search(MOST_POSITIVE);
      queue_search(32'sd0);

      // Empty table answers a miss
      set_size(0, 1'b0);
      queue_search(32'sd0);
      queue_search(MOST_NEGATIVE);

      // Five entries spanning the full range, rotated by three
      set_size(5, 1'b0);
      queue_write(0, 32'sd100);
      queue_write(1, MOST_POSITIVE);
      queue_write(2, MOST_NEGATIVE);
      queue_write(3, -32'sd5);
      queue_write(4, 32'sd7);
      queue_search(MOST_POSITIVE);
      queue_search(MOST_NEGATIVE);
      queue_search(32'sd7);
      queue_search(32'sd100);
      queue_search(32'sd6);
      queue_search(32'sd101);
      // Top table slot, then an entry out of order
      queue_write(rsts_pkg::TABLE_DEPTH - 1, 32'sh5555_5555);
      queue_write(3, 32'sd500);
      queue_search(32'sd500);
      queue_search(-32'sd5);

      // Random phases, mostly small tables
      while (random_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            size = 0;
         end else if (roll < 12) begin
            size = 1;
         end else if (roll < 85) begin
            size = $urandom_range(2, 48);
         end else begin
            size = $urandom_range(49, 200);
         end
         run_phase(size, 1'b1, $urandom_range(6, 20));
      end

      // Counts past the table depth through the register port
      set_size(2047, 1'b0);
      set_size($urandom_range(rsts_pkg::TABLE_DEPTH + 1, 2046), 1'b1);

      wait_drain();
      $display("Covered %0d searches (%0d found, %0d missed) and %0d table writes",
               search_count, hit_count, search_count - hit_count, write_count);
      $display("over %0d entry-count settings, from empty to beyond the table depth",
               size_settings);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[rotated_sorted_table_search.f]
hdl/rsts_pkg.sv
hdl/rsts_ram.sv
hdl/rsts_ctrl.sv
hdl/rotated_sorted_table_search.sv
dv/rotated_sorted_table_search_tb.sv
